// ===== rtl/c6502_pkg.sv =====
package c6502_pkg;

	// Operation codes
	localparam logic [5:0] ACT_LDA   = 6'd0;
	localparam logic [5:0] ACT_LDX   = 6'd1;
	localparam logic [5:0] ACT_LDY   = 6'd2;
	localparam logic [5:0] ACT_STA   = 6'd3;
	localparam logic [5:0] ACT_STX   = 6'd4;
	localparam logic [5:0] ACT_STY   = 6'd5;
	localparam logic [5:0] ACT_ADC   = 6'd6;
	localparam logic [5:0] ACT_SBC   = 6'd7;
	localparam logic [5:0] ACT_AND   = 6'd8;
	localparam logic [5:0] ACT_ORA   = 6'd9;
	localparam logic [5:0] ACT_EOR   = 6'd10;
	localparam logic [5:0] ACT_CMP   = 6'd11;
	localparam logic [5:0] ACT_CPX   = 6'd12;
	localparam logic [5:0] ACT_CPY   = 6'd13;
	localparam logic [5:0] ACT_BIT   = 6'd14;
	localparam logic [5:0] ACT_ASL_A = 6'd15;
	localparam logic [5:0] ACT_LSR_A = 6'd16;
	localparam logic [5:0] ACT_ROL_A = 6'd17;
	localparam logic [5:0] ACT_ROR_A = 6'd18;
	localparam logic [5:0] ACT_ASL_M = 6'd19;
	localparam logic [5:0] ACT_LSR_M = 6'd20;
	localparam logic [5:0] ACT_ROL_M = 6'd21;
	localparam logic [5:0] ACT_ROR_M = 6'd22;
	localparam logic [5:0] ACT_INC   = 6'd23;
	localparam logic [5:0] ACT_DEC   = 6'd24;
	localparam logic [5:0] ACT_INX   = 6'd25;
	localparam logic [5:0] ACT_INY   = 6'd26;
	localparam logic [5:0] ACT_DEX   = 6'd27;
	localparam logic [5:0] ACT_DEY   = 6'd28;
	localparam logic [5:0] ACT_TAX   = 6'd29;
	localparam logic [5:0] ACT_TAY   = 6'd30;
	localparam logic [5:0] ACT_TXA   = 6'd31;
	localparam logic [5:0] ACT_TYA   = 6'd32;
	localparam logic [5:0] ACT_TSX   = 6'd33;
	localparam logic [5:0] ACT_TXS   = 6'd34;
	localparam logic [5:0] ACT_PHA   = 6'd35;
	localparam logic [5:0] ACT_PHP   = 6'd36;
	localparam logic [5:0] ACT_PLA   = 6'd37;
	localparam logic [5:0] ACT_PLP   = 6'd38;
	localparam logic [5:0] ACT_CLC   = 6'd39;
	localparam logic [5:0] ACT_SEC   = 6'd40;
	localparam logic [5:0] ACT_CLI   = 6'd41;
	localparam logic [5:0] ACT_SEI   = 6'd42;
	localparam logic [5:0] ACT_CLV   = 6'd43;
	localparam logic [5:0] ACT_CLD   = 6'd44;
	localparam logic [5:0] ACT_SED   = 6'd45;
	localparam logic [5:0] ACT_NOP   = 6'd46;
	localparam logic [5:0] ACT_BPL   = 6'd47;
	localparam logic [5:0] ACT_BMI   = 6'd48;
	localparam logic [5:0] ACT_BVC   = 6'd49;
	localparam logic [5:0] ACT_BVS   = 6'd50;
	localparam logic [5:0] ACT_BCC   = 6'd51;
	localparam logic [5:0] ACT_BCS   = 6'd52;
	localparam logic [5:0] ACT_BNE   = 6'd53;
	localparam logic [5:0] ACT_BEQ   = 6'd54;

	// Status bit positions
	localparam int FLG_C = 0;
	localparam int FLG_Z = 1;
	localparam int FLG_I = 2;
	localparam int FLG_D = 3;
	localparam int FLG_B = 4;
	localparam int FLG_U = 5;
	localparam int FLG_V = 6;
	localparam int FLG_N = 7;

	localparam logic [7:0] SP_RESET = 8'hFD;

	// Architectural registers
	typedef struct packed {
		logic [7:0] acc;
		logic [7:0] idx_x;
		logic [7:0] idx_y;
		logic [7:0] sp;
		logic [7:0] status;
	} regs_t;

	// Per-operation side results
	typedef struct packed {
		logic       write_valid;
		logic [7:0] write_data;
		logic       stack_access;
		logic [7:0] stack_slot;
		logic       branch_taken;
	} side_t;

endpackage

// ===== rtl/c6502_cmd_if.sv =====
interface c6502_cmd_if;
	logic       valid;
	logic       ready;
	logic [5:0] action;
	logic [7:0] operand;

	modport source (output valid, action, operand, input ready);
	modport sink   (input valid, action, operand, output ready);
endinterface

// ===== rtl/c6502_res_if.sv =====
interface c6502_res_if;
	logic       valid;
	logic       ready;
	logic       write_valid;
	logic [7:0] write_data;
	logic       stack_access;
	logic [7:0] stack_slot;
	logic       branch_taken;
	logic [7:0] status_out;
	logic [7:0] acc_out;
	logic [7:0] index_x_out;
	logic [7:0] index_y_out;

	modport source (output valid, write_valid, write_data, stack_access, stack_slot,
		branch_taken, status_out, acc_out, index_x_out, index_y_out, input ready);
	modport sink   (input valid, write_valid, write_data, stack_access, stack_slot,
		branch_taken, status_out, acc_out, index_x_out, index_y_out, output ready);
endinterface

// ===== rtl/c6502_alu.sv =====
module c6502_alu (
	input  logic [5:0]         action,
	input  logic [7:0]         operand,
	input  c6502_pkg::regs_t   cur,
	output c6502_pkg::regs_t   nxt,
	output c6502_pkg::side_t   side
);

	// Z and N from a result byte
	function automatic logic [7:0] set_zn(input logic [7:0] p, input logic [7:0] v);
		logic [7:0] r;
		r = p;
		r[c6502_pkg::FLG_Z] = (v == 8'h00);
		r[c6502_pkg::FLG_N] = v[7];
		return r;
	endfunction

	logic [7:0] add_b;
	logic [8:0] add_sum;
	logic [7:0] cmp_reg;
	logic [8:0] cmp_diff;
	logic [7:0] sh_in;
	logic [7:0] sh_res;
	logic       sh_cout;
	logic [1:0] sh_kind;
	logic       cin;

	// Shared adder for ADC/SBC
	assign cin     = cur.status[c6502_pkg::FLG_C];
	assign add_b   = (action == c6502_pkg::ACT_SBC) ? ~operand : operand;
	assign add_sum = {1'b0, cur.acc} + {1'b0, add_b} + {8'h00, cin};

	// Shared comparator
	always_comb begin
		unique case (action)
			c6502_pkg::ACT_CPX: cmp_reg = cur.idx_x;
			c6502_pkg::ACT_CPY: cmp_reg = cur.idx_y;
			default:            cmp_reg = cur.acc;
		endcase
	end
	assign cmp_diff = {1'b0, cmp_reg} - {1'b0, operand};

	// Shared shifter: kind 0 ASL, 1 LSR, 2 ROL, 3 ROR
	assign sh_in   = (action <= c6502_pkg::ACT_ROR_A) ? cur.acc : operand;
	assign sh_kind = (action <= c6502_pkg::ACT_ROR_A)
		? 2'(action - c6502_pkg::ACT_ASL_A) : 2'(action - c6502_pkg::ACT_ASL_M);
	always_comb begin
		unique case (sh_kind)
			2'd0: begin sh_res = {sh_in[6:0], 1'b0}; sh_cout = sh_in[7]; end
			2'd1: begin sh_res = {1'b0, sh_in[7:1]}; sh_cout = sh_in[0]; end
			2'd2: begin sh_res = {sh_in[6:0], cin};  sh_cout = sh_in[7]; end
			default: begin sh_res = {cin, sh_in[7:1]}; sh_cout = sh_in[0]; end
		endcase
	end

	// Operation decode
	always_comb begin
		logic [7:0] v;
		v    = 8'h00;
		nxt  = cur;
		side = '0;
		unique case (action)
			c6502_pkg::ACT_LDA: begin nxt.acc = operand; nxt.status = set_zn(cur.status, operand); end
			c6502_pkg::ACT_LDX: begin nxt.idx_x = operand; nxt.status = set_zn(cur.status, operand); end
			c6502_pkg::ACT_LDY: begin nxt.idx_y = operand; nxt.status = set_zn(cur.status, operand); end
			c6502_pkg::ACT_STA: begin side.write_valid = 1'b1; side.write_data = cur.acc; end
			c6502_pkg::ACT_STX: begin side.write_valid = 1'b1; side.write_data = cur.idx_x; end
			c6502_pkg::ACT_STY: begin side.write_valid = 1'b1; side.write_data = cur.idx_y; end
			c6502_pkg::ACT_ADC, c6502_pkg::ACT_SBC: begin
				v = add_sum[7:0];
				nxt.acc = v;
				nxt.status = set_zn(cur.status, v);
				nxt.status[c6502_pkg::FLG_C] = add_sum[8];
				nxt.status[c6502_pkg::FLG_V] = ~(cur.acc[7] ^ add_b[7]) & (cur.acc[7] ^ v[7]);
			end
			c6502_pkg::ACT_AND: begin
				v = cur.acc & operand; nxt.acc = v; nxt.status = set_zn(cur.status, v);
			end
			c6502_pkg::ACT_ORA: begin
				v = cur.acc | operand; nxt.acc = v; nxt.status = set_zn(cur.status, v);
			end
			c6502_pkg::ACT_EOR: begin
				v = cur.acc ^ operand; nxt.acc = v; nxt.status = set_zn(cur.status, v);
			end
			c6502_pkg::ACT_CMP, c6502_pkg::ACT_CPX, c6502_pkg::ACT_CPY: begin
				nxt.status = set_zn(cur.status, cmp_diff[7:0]);
				nxt.status[c6502_pkg::FLG_C] = ~cmp_diff[8];
			end
			c6502_pkg::ACT_BIT: begin
				nxt.status[c6502_pkg::FLG_Z] = ((cur.acc & operand) == 8'h00);
				nxt.status[c6502_pkg::FLG_N] = operand[7];
				nxt.status[c6502_pkg::FLG_V] = operand[6];
			end
			c6502_pkg::ACT_ASL_A, c6502_pkg::ACT_LSR_A,
			c6502_pkg::ACT_ROL_A, c6502_pkg::ACT_ROR_A: begin
				nxt.acc = sh_res;
				nxt.status = set_zn(cur.status, sh_res);
				nxt.status[c6502_pkg::FLG_C] = sh_cout;
			end
			c6502_pkg::ACT_ASL_M, c6502_pkg::ACT_LSR_M,
			c6502_pkg::ACT_ROL_M, c6502_pkg::ACT_ROR_M: begin
				side.write_valid = 1'b1;
				side.write_data = sh_res;
				nxt.status = set_zn(cur.status, sh_res);
				nxt.status[c6502_pkg::FLG_C] = sh_cout;
			end
			c6502_pkg::ACT_INC: begin
				v = operand + 8'd1;
				side.write_valid = 1'b1; side.write_data = v;
				nxt.status = set_zn(cur.status, v);
			end
			c6502_pkg::ACT_DEC: begin
				v = operand - 8'd1;
				side.write_valid = 1'b1; side.write_data = v;
				nxt.status = set_zn(cur.status, v);
			end
			c6502_pkg::ACT_INX: begin
				v = cur.idx_x + 8'd1; nxt.idx_x = v; nxt.status = set_zn(cur.status, v);
			end
			c6502_pkg::ACT_INY: begin
				v = cur.idx_y + 8'd1; nxt.idx_y = v; nxt.status = set_zn(cur.status, v);
			end
			c6502_pkg::ACT_DEX: begin
				v = cur.idx_x - 8'd1; nxt.idx_x = v; nxt.status = set_zn(cur.status, v);
			end
			c6502_pkg::ACT_DEY: begin
				v = cur.idx_y - 8'd1; nxt.idx_y = v; nxt.status = set_zn(cur.status, v);
			end
			c6502_pkg::ACT_TAX: begin nxt.idx_x = cur.acc; nxt.status = set_zn(cur.status, cur.acc); end
			c6502_pkg::ACT_TAY: begin nxt.idx_y = cur.acc; nxt.status = set_zn(cur.status, cur.acc); end
			c6502_pkg::ACT_TXA: begin nxt.acc = cur.idx_x; nxt.status = set_zn(cur.status, cur.idx_x); end
			c6502_pkg::ACT_TYA: begin nxt.acc = cur.idx_y; nxt.status = set_zn(cur.status, cur.idx_y); end
			c6502_pkg::ACT_TSX: begin nxt.idx_x = cur.sp; nxt.status = set_zn(cur.status, cur.sp); end
			c6502_pkg::ACT_TXS: nxt.sp = cur.idx_x;
			c6502_pkg::ACT_PHA, c6502_pkg::ACT_PHP: begin
				side.write_valid = 1'b1;
				side.stack_access = 1'b1;
				side.stack_slot = cur.sp;
				side.write_data = (action == c6502_pkg::ACT_PHA) ? cur.acc : (cur.status | 8'h30);
				nxt.sp = cur.sp - 8'd1;
			end
			c6502_pkg::ACT_PLA, c6502_pkg::ACT_PLP: begin
				v = cur.sp + 8'd1;
				nxt.sp = v;
				side.stack_access = 1'b1;
				side.stack_slot = v;
				if (action == c6502_pkg::ACT_PLA) begin
					nxt.acc = operand;
					nxt.status = set_zn(cur.status, operand);
				end else begin
					nxt.status = operand & 8'hCF;
				end
			end
			c6502_pkg::ACT_CLC: nxt.status[c6502_pkg::FLG_C] = 1'b0;
			c6502_pkg::ACT_SEC: nxt.status[c6502_pkg::FLG_C] = 1'b1;
			c6502_pkg::ACT_CLI: nxt.status[c6502_pkg::FLG_I] = 1'b0;
			c6502_pkg::ACT_SEI: nxt.status[c6502_pkg::FLG_I] = 1'b1;
			c6502_pkg::ACT_CLV: nxt.status[c6502_pkg::FLG_V] = 1'b0;
			c6502_pkg::ACT_CLD: nxt.status[c6502_pkg::FLG_D] = 1'b0;
			c6502_pkg::ACT_SED: nxt.status[c6502_pkg::FLG_D] = 1'b1;
			c6502_pkg::ACT_BPL: side.branch_taken = ~cur.status[c6502_pkg::FLG_N];
			c6502_pkg::ACT_BMI: side.branch_taken =  cur.status[c6502_pkg::FLG_N];
			c6502_pkg::ACT_BVC: side.branch_taken = ~cur.status[c6502_pkg::FLG_V];
			c6502_pkg::ACT_BVS: side.branch_taken =  cur.status[c6502_pkg::FLG_V];
			c6502_pkg::ACT_BCC: side.branch_taken = ~cur.status[c6502_pkg::FLG_C];
			c6502_pkg::ACT_BCS: side.branch_taken =  cur.status[c6502_pkg::FLG_C];
			c6502_pkg::ACT_BNE: side.branch_taken = ~cur.status[c6502_pkg::FLG_Z];
			c6502_pkg::ACT_BEQ: side.branch_taken =  cur.status[c6502_pkg::FLG_Z];
			// NOP and unused codes change nothing
			default: ;
		endcase
	end

endmodule

// ===== rtl/cpu6502_register_alu_execute_core.sv =====
// 6502 execute core (binary arithmetic only). Each transfer on cmd carries one decoded
// operation and its operand byte; each produces exactly one transfer on res with any
// memory or stack write, the branch condition, and A, X, Y and status after the
// operation. Throughput is one operation per clock while res is ready; each operation
// passes the input register, then the result register, with the combinational ALU
// between them. Registers update as an operation moves into the result register, so a
// following operation sees them at once. Reset: A = X = Y = 0, S = 0xFD, status = 0.
module cpu6502_register_alu_execute_core (
	input  logic       clk,
	input  logic       arst_n,
	c6502_cmd_if.sink   cmd,
	c6502_res_if.source res
);

	logic             valid_s1;
	logic [5:0]       action_s1;
	logic [7:0]       operand_s1;
	logic             res_valid_q;
	logic             adv;
	c6502_pkg::regs_t regs_q;
	c6502_pkg::regs_t regs_nxt;
	c6502_pkg::side_t side;

	// Handshake: stage 1 moves on when the result register is free or drained
	assign adv       = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			action_s1  <= cmd.action;
			operand_s1 <= cmd.operand;
		end
	end

	c6502_alu u_alu (
		.action  (action_s1),
		.operand (operand_s1),
		.cur     (regs_q),
		.nxt     (regs_nxt),
		.side    (side)
	);

	// Architectural registers commit with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '{acc: 8'h00, idx_x: 8'h00, idx_y: 8'h00,
				sp: c6502_pkg::SP_RESET, status: 8'h00};
		end else if (adv) begin
			regs_q <= regs_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || res.ready) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res.write_valid  <= side.write_valid;
			res.write_data   <= side.write_data;
			res.stack_access <= side.stack_access;
			res.stack_slot   <= side.stack_slot;
			res.branch_taken <= side.branch_taken;
			res.status_out   <= regs_nxt.status;
			res.acc_out      <= regs_nxt.acc;
			res.index_x_out  <= regs_nxt.idx_x;
			res.index_y_out  <= regs_nxt.idx_y;
		end
	end

	assign res.valid = res_valid_q;

endmodule
